>>> design/ata_drive_timing_word_top_macros.svh
// assertion helpers shared by the timing word block
`ifndef ATA_DRIVE_TIMING_WORD_TOP_MACROS_SVH
`define ATA_DRIVE_TIMING_WORD_TOP_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define ATADT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timing word check failed");

// next-cycle implication, quiet while reset is held
`define ATADT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timing word check failed");

`endif

>>> design/atadt_pkg.sv
package atadt_pkg;

  localparam int unsigned WORD_W = 29;

  localparam logic [WORD_W-1:0] UDMA_ENABLE_BIT = WORD_W'(32'h0010_0000);

  typedef struct packed {
    logic       present;
    logic [2:0] pio_sel;
    logic       dma_on;
    logic [1:0] dma_sel;
    logic       udma_on;
    logic [2:0] udma_sel;
  } drive_mode_t;

  typedef struct packed {
    logic       drive0_present;
    logic [2:0] drive0_pio_mode;
    logic       drive0_dma_on;
    logic [1:0] drive0_dma_mode;
    logic       drive0_udma_on;
    logic [2:0] drive0_udma_mode;
    logic       drive1_present;
    logic [2:0] drive1_pio_mode;
    logic       drive1_dma_on;
    logic [1:0] drive1_dma_mode;
    logic       drive1_udma_on;
    logic [2:0] drive1_udma_mode;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] drive0_timing;
    logic [WORD_W-1:0] drive1_timing;
    logic              write_now;
    logic              initial_drive;
    logic              switch_per_select;
  } out_item_t;

  // pio part: rec at bit 5, act at bit 0; counts already tick-rounded
  function automatic logic [WORD_W-1:0] pio_word(input logic [2:0] mode, input logic newer);
    logic [4:0] act;
    logic [4:0] rec;
    act = '0;
    rec = '0;
    if (newer) begin
      case (mode)
        3'd0: begin act = 5'd12; rec = 5'd28; end
        3'd1: begin act = 5'd10; rec = 5'd16; end
        3'd2: begin act = 5'd7;  rec = 5'd9;  end
        3'd3: begin act = 5'd6;  rec = 5'd6;  end
        default: begin act = 5'd5; rec = 5'd3; end
      endcase
    end else begin
      // 30 ns ticks, recovery less the pio offset, floor of one
      case (mode)
        3'd0: begin act = 5'd6; rec = 5'd10; end
        3'd1: begin act = 5'd5; rec = 5'd4;  end
        3'd2: begin act = 5'd4; rec = 5'd1;  end
        3'd3: begin act = 5'd3; rec = 5'd1;  end
        default: begin act = 5'd3; rec = 5'd1; end
      endcase
    end
    return (WORD_W'(rec) << 5) | WORD_W'(act);
  endfunction

  function automatic logic [WORD_W-1:0] dma_word(input logic [1:0] mode, input logic newer);
    logic [4:0] act;
    logic [4:0] rec;
    logic [WORD_W-1:0] w;
    act = '0;
    rec = '0;
    if (newer) begin
      case (mode)
        2'd0: begin act = 5'd16; rec = 5'd16; end
        2'd1: begin act = 5'd6;  rec = 5'd5;  end
        default: begin act = 5'd5; rec = 5'd3; end
      endcase
      w = (WORD_W'(act) << 10) | (WORD_W'(rec) << 15);
    end else begin
      case (mode)
        2'd0: begin act = 5'd8; rec = 5'd7; end
        2'd1: begin act = 5'd3; rec = 5'd2; end
        default: begin act = 5'd3; rec = 5'd1; end
      endcase
      w = (WORD_W'(rec) << 16) | (WORD_W'(act) << 11);
    end
    return w;
  endfunction

  // ultra dma exists on the newer controller only
  function automatic logic [WORD_W-1:0] udma_word(input logic [2:0] mode);
    logic [3:0] cyc;
    logic [3:0] act;
    case (mode)
      3'd0: begin cyc = 4'd8; act = 4'd12; end
      3'd1: begin cyc = 4'd6; act = 4'd10; end
      3'd2: begin cyc = 4'd4; act = 4'd8;  end
      3'd3: begin cyc = 4'd3; act = 4'd6;  end
      default: begin cyc = 4'd2; act = 4'd6; end
    endcase
    return (WORD_W'(cyc) << 21) | (WORD_W'(act) << 25) | UDMA_ENABLE_BIT;
  endfunction

endpackage

>>> design/atadt_word.sv
module atadt_word (
  input  atadt_pkg::drive_mode_t         mode,
  input  logic                           newer,
  output logic [atadt_pkg::WORD_W-1:0]   word
);

  logic [atadt_pkg::WORD_W-1:0] pio_part;
  logic [atadt_pkg::WORD_W-1:0] dma_part;
  logic [atadt_pkg::WORD_W-1:0] udma_part;

  always_comb begin
    pio_part  = mode.present ? atadt_pkg::pio_word(mode.pio_sel, newer) : '0;
    dma_part  = mode.dma_on ? atadt_pkg::dma_word(mode.dma_sel, newer) : '0;
    udma_part = (newer && mode.udma_on) ? atadt_pkg::udma_word(mode.udma_sel) : '0;
    // parts that overlap are simply ored
    word      = pio_part | dma_part | udma_part;
  end

endmodule

>>> design/ata_drive_timing_word_top.sv
// a request accepted into the input register passes through lookup and packing into the result register
// throughput: one request per cycle while out_stall is low; lookup and packing sit between two registers
// an input register and a result register let a new request in while a result waits
// reset (synchronous, rst high) empties both stages and sets controller_kind to classic
`include "ata_drive_timing_word_top_macros.svh"

module ata_drive_timing_word_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  atadt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output atadt_pkg::out_item_t out_data
);

  logic                         controller_kind;
  logic                         req_valid;
  atadt_pkg::in_item_t          req;
  logic                         adv_out;
  logic                         adv_req;
  atadt_pkg::drive_mode_t       mode0;
  atadt_pkg::drive_mode_t       mode1;
  logic [atadt_pkg::WORD_W-1:0] word0;
  logic [atadt_pkg::WORD_W-1:0] word1;
  atadt_pkg::out_item_t         result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      controller_kind <= 1'b0;
    end else if (cfg_wr_en) begin
      controller_kind <= cfg_wr_data;
    end
  end

  assign adv_out  = !out_valid || !out_stall;
  assign adv_req  = !req_valid || adv_out;
  assign in_stall = !adv_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (adv_req) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_req && in_valid) begin
      req <= in_data;
    end
  end

  assign mode0 = '{present:  req.drive0_present,
                   pio_sel:  req.drive0_pio_mode,
                   dma_on:   req.drive0_dma_on,
                   dma_sel:  req.drive0_dma_mode,
                   udma_on:  req.drive0_udma_on,
                   udma_sel: req.drive0_udma_mode};
  assign mode1 = '{present:  req.drive1_present,
                   pio_sel:  req.drive1_pio_mode,
                   dma_on:   req.drive1_dma_on,
                   dma_sel:  req.drive1_dma_mode,
                   udma_on:  req.drive1_udma_on,
                   udma_sel: req.drive1_udma_mode};

  atadt_word u_word0 (
    .mode  (mode0),
    .newer (controller_kind),
    .word  (word0)
  );

  atadt_word u_word1 (
    .mode  (mode1),
    .newer (controller_kind),
    .word  (word1)
  );

  always_comb begin
    result_next.drive0_timing     = word0;
    result_next.drive1_timing     = word1;
    result_next.write_now         = (|word0) || (|word1);
    result_next.initial_drive     = !(|word0) && (|word1);
    result_next.switch_per_select = (|word0) && (|word1) && (word0 != word1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && req_valid) begin
      out_data <= result_next;
    end
  end

  `ATADT_ASSERT_NOW(a_stall_when_full, clk, rst, req_valid && out_valid && out_stall, in_stall)
  `ATADT_ASSERT_NEXT(a_req_moves_on, clk, rst, req_valid && !out_stall, out_valid)
  `ATADT_ASSERT_NOW(a_write_now_match, clk, rst, out_valid, out_data.write_now == ((|out_data.drive0_timing) || (|out_data.drive1_timing)))
  `ATADT_ASSERT_NOW(a_switch_implies_first, clk, rst, out_valid && out_data.switch_per_select, out_data.write_now && !out_data.initial_drive)

endmodule

>>> tb/timing_word_checker.sv
module timing_word_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  atadt_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  atadt_pkg::out_item_t out_data,
  output int                   fails,
  output int                   awaited
);

  typedef enum logic [1:0] {TBL_PIO, TBL_MWDMA, TBL_UDMA} mode_table_e;

  typedef struct packed {
    logic [9:0] cycle_ns;
    logic [9:0] active_ns;
  } ns_pair_t;

  logic                 newer_ctrl;
  atadt_pkg::out_item_t timing_q[$];

  function automatic ns_pair_t min_times(input mode_table_e tbl, input int unsigned m);
    ns_pair_t t;
    t = '0;
    case (tbl)
      TBL_PIO: begin
        case (m)
          0: t = {10'd600, 10'd180};
          1: t = {10'd390, 10'd150};
          2: t = {10'd240, 10'd105};
          3: t = {10'd180, 10'd90};
          default: t = {10'd120, 10'd75};
        endcase
      end
      TBL_MWDMA: begin
        case (m)
          0: t = {10'd480, 10'd240};
          1: t = {10'd165, 10'd90};
          default: t = {10'd120, 10'd75};
        endcase
      end
      default: begin
        case (m)
          0: t = {10'd120, 10'd180};
          1: t = {10'd90, 10'd150};
          2: t = {10'd60, 10'd120};
          3: t = {10'd45, 10'd90};
          default: t = {10'd30, 10'd90};
        endcase
      end
    endcase
    return t;
  endfunction

  function automatic int unsigned ns_to_ticks(input int unsigned ns, input int unsigned tick);
    return (ns + tick - 1) / tick;
  endfunction

  function automatic logic [atadt_pkg::WORD_W-1:0] drive_timing(
      input atadt_pkg::drive_mode_t d, input logic newer);
    int unsigned tick;
    int unsigned cyc;
    int unsigned act;
    int unsigned rec;
    int unsigned m;
    ns_pair_t    t;
    logic [31:0] w;
    w = '0;
    tick = newer ? 15 : 30;
    if (d.present) begin
      m = (d.pio_sel > 4) ? 4 : 32'(d.pio_sel);
      t = min_times(TBL_PIO, m);
      cyc = ns_to_ticks(32'(t.cycle_ns), tick);
      act = ns_to_ticks(32'(t.active_ns), tick);
      if (newer) begin
        rec = cyc - act;
      end else begin
        if (act < 1) act = 1;
        // classic pio recovery loses four ticks, never below one
        rec = (cyc > act + 5) ? cyc - act - 4 : 1;
      end
      w |= (rec << 5) | act;
    end
    if (d.dma_on) begin
      m = (d.dma_sel > 2) ? 2 : 32'(d.dma_sel);
      t = min_times(TBL_MWDMA, m);
      cyc = ns_to_ticks(32'(t.cycle_ns), tick);
      act = ns_to_ticks(32'(t.active_ns), tick);
      if (newer) begin
        rec = cyc - act;
        w |= (act << 10) | (rec << 15);
      end else begin
        rec = (cyc > act + 2) ? cyc - act - 1 : 1;
        w |= (rec << 16) | (act << 11);
      end
    end
    // ultra dma only on the newer controller
    if (newer && d.udma_on) begin
      m = (d.udma_sel > 4) ? 4 : 32'(d.udma_sel);
      t = min_times(TBL_UDMA, m);
      cyc = ns_to_ticks(32'(t.cycle_ns), tick);
      act = ns_to_ticks(32'(t.active_ns), tick);
      w |= (cyc << 21) | (act << 25) | 32'h0010_0000;
    end
    return w[atadt_pkg::WORD_W-1:0];
  endfunction

  function automatic atadt_pkg::out_item_t predict_timing(input atadt_pkg::in_item_t req,
                                                          input logic newer);
    atadt_pkg::drive_mode_t d0;
    atadt_pkg::drive_mode_t d1;
    atadt_pkg::out_item_t   r;
    {d0, d1} = req;
    r.drive0_timing = drive_timing(d0, newer);
    r.drive1_timing = drive_timing(d1, newer);
    r.write_now = (r.drive0_timing != '0) || (r.drive1_timing != '0);
    r.initial_drive = (r.drive0_timing == '0) && (r.drive1_timing != '0);
    r.switch_per_select = (r.drive0_timing != '0) && (r.drive1_timing != '0)
                          && (r.drive0_timing != r.drive1_timing);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at %0t: %s", $time, what);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    atadt_pkg::out_item_t want;
    if (rst) begin
      newer_ctrl = 1'b0;
      timing_q.delete();
    end else begin
      if (cfg_wr_en) newer_ctrl = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (timing_q.size() == 0) begin
          report_mismatch("result with no request awaiting it");
        end else begin
          want = timing_q.pop_front();
          check_field("drive0_timing", 32'(out_data.drive0_timing),
                      32'(want.drive0_timing));
          check_field("drive1_timing", 32'(out_data.drive1_timing),
                      32'(want.drive1_timing));
          check_field("write_now", 32'(out_data.write_now), 32'(want.write_now));
          check_field("initial_drive", 32'(out_data.initial_drive),
                      32'(want.initial_drive));
          check_field("switch_per_select", 32'(out_data.switch_per_select),
                      32'(want.switch_per_select));
        end
      end
      if (in_valid && !in_stall) timing_q.push_back(predict_timing(in_data, newer_ctrl));
    end
    awaited = timing_q.size();
  end

endmodule

>>> tb/tb.sv
module tb;

  typedef enum logic {CTRL_CLASSIC = 1'b0, CTRL_NEWER = 1'b1} ctrl_kind_e;

  localparam int STALL_LIMIT      = 200;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int PHASES           = 4;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic                 cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  atadt_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  atadt_pkg::out_item_t out_data;

  int                   fails;
  int                   awaited;
  int                   idle_cycles;
  bit                   tx_quiet;
  bit                   rx_quiet;
  atadt_pkg::in_item_t  directed_q[$];

  ata_drive_timing_word_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  timing_word_checker word_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fails      (fails),
    .awaited    (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // no handshake of any kind for too long means the block has hung
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic atadt_pkg::drive_mode_t drive_setup(input bit present, input int pio,
                                                         input bit dma_on, input int dma_sel,
                                                         input bit udma_on, input int udma_sel);
    atadt_pkg::drive_mode_t d;
    d.present  = present;
    d.pio_sel  = 3'(pio);
    d.dma_on   = dma_on;
    d.dma_sel  = 2'(dma_sel);
    d.udma_on  = udma_on;
    d.udma_sel = 3'(udma_sel);
    return d;
  endfunction

  function automatic atadt_pkg::drive_mode_t random_drive();
    atadt_pkg::drive_mode_t d;
    logic [10:0] raw;
    raw = 11'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      // any bit pattern, mode numbers past the tables included
      d = raw;
    end else begin
      d = drive_setup($urandom_range(0, 3) != 0, $urandom_range(0, 4),
                      1'($urandom_range(0, 1)), $urandom_range(0, 2),
                      1'($urandom_range(0, 1)), $urandom_range(0, 4));
    end
    return d;
  endfunction

  task automatic send_request(input atadt_pkg::in_item_t req);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_controller(input ctrl_kind_e kind);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = kind;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  task automatic drain();
    while (awaited != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : receiver
    int n;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      n = rx_quiet ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    ctrl_kind_e kind;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;

    directed_q.push_back({drive_setup(0, 0, 0, 0, 0, 0), drive_setup(0, 0, 0, 0, 0, 0)});
    directed_q.push_back({drive_setup(1, 7, 1, 3, 1, 7), drive_setup(1, 7, 1, 3, 1, 7)});
    directed_q.push_back({drive_setup(0, 0, 1, 0, 0, 0), drive_setup(1, 0, 0, 0, 0, 0)});
    directed_q.push_back({drive_setup(0, 0, 0, 0, 0, 0), drive_setup(1, 4, 0, 0, 0, 0)});
    directed_q.push_back({drive_setup(1, 1, 0, 0, 0, 0), drive_setup(1, 2, 1, 1, 0, 0)});
    directed_q.push_back({drive_setup(1, 3, 1, 2, 0, 0), drive_setup(1, 3, 1, 2, 0, 0)});
    // ultra dma alone: nothing at all on the classic controller
    directed_q.push_back({drive_setup(0, 0, 0, 0, 1, 0), drive_setup(0, 0, 0, 0, 1, 1)});
    directed_q.push_back({drive_setup(1, 0, 0, 0, 1, 2), drive_setup(1, 4, 1, 0, 1, 3)});
    directed_q.push_back({drive_setup(1, 4, 1, 1, 1, 4), drive_setup(0, 0, 0, 0, 0, 0)});
    // mode numbers past the tables saturate
    directed_q.push_back({drive_setup(1, 5, 1, 3, 1, 5), drive_setup(1, 6, 0, 3, 1, 6)});
    directed_q.push_back({drive_setup(1, 7, 0, 1, 0, 7), drive_setup(0, 7, 0, 3, 0, 7)});
    directed_q.push_back({drive_setup(1, 2, 1, 0, 0, 4), drive_setup(1, 1, 1, 0, 1, 0)});

    repeat (8) @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      kind = ph[0] ? CTRL_NEWER : CTRL_CLASSIC;
      set_controller(kind);
      if (ph < 2) begin
        foreach (directed_q[i]) send_request(directed_q[i]);
      end
      repeat (RANDOM_PER_PHASE) send_request({random_drive(), random_drive()});
      in_valid = 1'b0;
      drain();
    end

    if (fails == 0 && awaited == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
